### design/dwsc_pkg.sv
`default_nettype none
package dwsc_pkg;

  localparam int unsigned PERIOD_TICKS_DEF = 10;
  localparam int unsigned CORR_LIMIT_DEF   = 31199;

  localparam int unsigned TARGET_W  = 7;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned TOTAL_W   = 16;
  localparam int unsigned DUTY_W    = 16;
  localparam int unsigned PHASE_W   = 4;
  localparam int unsigned ERR_W     = TARGET_W + 1;
  localparam int unsigned SYNC_W    = TOTAL_W + 1;
  localparam int unsigned LIMIT_W   = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] KP_RESET = 16'd5120;
  localparam logic [GAIN_W-1:0] KI_RESET = 16'd102;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_LEFT,
    CFG_TARGET_RIGHT,
    CFG_KP_GAIN,
    CFG_KI_GAIN
  } cfg_idx_e;

  // operands one wheel lane needs for its correction
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [SYNC_W-1:0] sync;
  } lane_op_t;

  typedef struct packed {
    lane_op_t                 left;
    lane_op_t                 right;
    logic [TOTAL_W-1:0]       total_left;
    logic [TOTAL_W-1:0]       total_right;
    logic                     updated;
  } front_out_t;

  typedef struct packed {
    logic load2;
    logic load3;
    logic upd2;
  } pipe_ctl_t;

endpackage
`default_nettype wire

### design/dwsc_front.sv
`default_nettype none
module dwsc_front #(
  parameter int unsigned PERIOD_TICKS = dwsc_pkg::PERIOD_TICKS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic                          left_pulse_i,
  input  wire logic                          right_pulse_i,
  input  wire logic                          ms_tick_i,
  input  wire logic                          clear_i,
  input  wire logic [dwsc_pkg::TARGET_W-1:0] target_left_i,
  input  wire logic [dwsc_pkg::TARGET_W-1:0] target_right_i,
  output dwsc_pkg::front_out_t               out_o
);
  import dwsc_pkg::*;

  localparam logic [TARGET_W-1:0] CNT_MAX = {TARGET_W{1'b1}};

  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [TARGET_W-1:0] cnt_l_q, cnt_l_d, cnt_r_q, cnt_r_d;
  logic [TOTAL_W-1:0]  tot_l_q, tot_l_d, tot_r_q, tot_r_d;

  logic [TARGET_W-1:0] cnt_l_inc, cnt_r_inc;
  logic [PHASE_W:0]    phase_nx;
  logic                upd;
  logic [TOTAL_W-1:0]  tot_l_new, tot_r_new, diff;
  logic signed [SYNC_W-1:0] sync_r;

  always_comb begin
    cnt_l_inc = (left_pulse_i && cnt_l_q != CNT_MAX) ? cnt_l_q + 1'b1 : cnt_l_q;
    cnt_r_inc = (right_pulse_i && cnt_r_q != CNT_MAX) ? cnt_r_q + 1'b1 : cnt_r_q;
    phase_nx  = {1'b0, phase_q} + 1'b1;
    upd       = ms_tick_i && (phase_nx >= (PHASE_W+1)'(PERIOD_TICKS));
    tot_l_new = upd ? tot_l_q + TOTAL_W'(cnt_l_inc) : tot_l_q;
    tot_r_new = upd ? tot_r_q + TOTAL_W'(cnt_r_inc) : tot_r_q;
    diff      = tot_l_new - tot_r_new;
    sync_r    = $signed({diff[TOTAL_W-1], diff});

    out_o.left.err    = $signed({1'b0, target_left_i}) - $signed({1'b0, cnt_l_inc});
    out_o.right.err   = $signed({1'b0, target_right_i}) - $signed({1'b0, cnt_r_inc});
    out_o.left.sync   = -sync_r;
    out_o.right.sync  = sync_r;
    out_o.total_left  = tot_l_new;
    out_o.total_right = tot_r_new;
    out_o.updated     = upd;

    phase_d = phase_q;
    cnt_l_d = cnt_l_q;
    cnt_r_d = cnt_r_q;
    tot_l_d = tot_l_q;
    tot_r_d = tot_r_q;
    if (accept_i) begin
      if (upd) begin
        phase_d = '0;
      end else if (ms_tick_i) begin
        phase_d = phase_nx[PHASE_W-1:0];
      end
      // restart both counts at the period end
      cnt_l_d = upd ? '0 : cnt_l_inc;
      cnt_r_d = upd ? '0 : cnt_r_inc;
      // clear lands after this item's update
      tot_l_d = clear_i ? '0 : tot_l_new;
      tot_r_d = clear_i ? '0 : tot_r_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      cnt_l_q <= '0;
      cnt_r_q <= '0;
      tot_l_q <= '0;
      tot_r_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_l_q <= cnt_l_d;
      cnt_r_q <= cnt_r_d;
      tot_l_q <= tot_l_d;
      tot_r_q <= tot_r_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PHASE_W+1)'(phase_q) < (PHASE_W+1)'(PERIOD_TICKS))
    else $error("period phase out of range");

  a_update_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && upd) |=> (phase_q == '0 && cnt_l_q == '0 && cnt_r_q == '0))
    else $error("period state not restarted after update");

endmodule
`default_nettype wire

### design/dwsc_lane.sv
`default_nettype none
module dwsc_lane #(
  parameter int unsigned CORRECTION_LIMIT = dwsc_pkg::CORR_LIMIT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dwsc_pkg::pipe_ctl_t         ctl_i,
  input  wire dwsc_pkg::lane_op_t          op_i,
  input  wire logic [dwsc_pkg::GAIN_W-1:0] kp_gain_i,
  input  wire logic [dwsc_pkg::GAIN_W-1:0] ki_gain_i,
  output logic      [dwsc_pkg::DUTY_W-1:0] duty_o
);
  import dwsc_pkg::*;

  localparam int unsigned KP_PROD_W = GAIN_W + 1 + ERR_W;
  localparam int unsigned KI_PROD_W = GAIN_W + 1 + SYNC_W;
  localparam int unsigned CORR_W    = KI_PROD_W + 1;
  localparam int unsigned CLIP_W    = LIMIT_W + 1;
  localparam int unsigned SUM_W     = DUTY_W + 2;
  localparam logic signed [CORR_W-1:0] LIM_P = CORR_W'(CORRECTION_LIMIT);
  localparam logic signed [CORR_W-1:0] LIM_N = -LIM_P;

  logic signed [KP_PROD_W-1:0] prod_kp_q;
  logic signed [KI_PROD_W-1:0] prod_ki_q;
  logic [DUTY_W-1:0]           duty_q, duty_d;

  logic signed [CORR_W-1:0] corr, corr_clamped;
  logic signed [CLIP_W-1:0] clip;
  logic signed [SUM_W-1:0]  sum;

  // stage 2: one multiplier per gain
  always_ff @(posedge clk_i) begin
    if (ctl_i.load2) begin
      prod_kp_q <= $signed({1'b0, kp_gain_i}) * op_i.err;
      prod_ki_q <= $signed({1'b0, ki_gain_i}) * op_i.sync;
    end
  end

  // stage 3: sum, clamp, apply to duty
  always_comb begin
    corr = CORR_W'(prod_kp_q) + CORR_W'(prod_ki_q);
    if (corr > LIM_P) begin
      corr_clamped = LIM_P;
    end else if (corr < LIM_N) begin
      corr_clamped = LIM_N;
    end else begin
      corr_clamped = corr;
    end
    clip = corr_clamped[CLIP_W-1:0];
    sum  = $signed({2'b00, duty_q}) + SUM_W'(clip);
    duty_d = duty_q;
    if (ctl_i.load3 && ctl_i.upd2) begin
      if (sum[SUM_W-1]) begin
        duty_d = '0;
      end else if (sum[SUM_W-2]) begin
        duty_d = '1;
      end else begin
        duty_d = sum[DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
    end else begin
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

  a_duty_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.load3 && ctl_i.upd2) |=> $stable(duty_q))
    else $error("duty moved without a control update");

endmodule
`default_nettype wire

### design/dual_wheel_sync_speed_controller.sv
// Pipeline: an accepted item passes period state, gain multiply, and clamp and
// duty update in turn, each one register stage.
// Throughput: one item per cycle while the output is taken; the output register
// and per-stage enables keep the input open while a result waits in an emptier pipe.
// Reset: asynchronous, active low; clears phase, counts, totals, duties and
// loads the default targets and gains. No clearing pass is needed.
`default_nettype none
module dual_wheel_sync_speed_controller #(
  parameter int unsigned PERIOD_TICKS     = dwsc_pkg::PERIOD_TICKS_DEF,
  parameter int unsigned CORRECTION_LIMIT = dwsc_pkg::CORR_LIMIT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [0] left_pulse, [1] right_pulse, [2] ms_tick, [3] clear_totals, [7:4] zero
  input  wire logic [7:0]                      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [15:0] duty_left, [31:16] duty_right, [47:32] total_left,
  // [63:48] total_right, [64] updated, [71:65] zero
  output logic [71:0]                          m_axis_tdata,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dwsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dwsc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dwsc_pkg::*;

  logic [TARGET_W-1:0] target_l_q, target_r_q;
  logic [GAIN_W-1:0]   kp_q, ki_q;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3, s_acc;
  front_out_t front_out, s1_q;
  logic [TOTAL_W-1:0] tl2_q, tr2_q, tl3_q, tr3_q;
  logic upd2_q, upd3_q;
  pipe_ctl_t ctl;
  logic [DUTY_W-1:0] duty_left, duty_right;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_l_q <= '0;
      target_r_q <= '0;
      kp_q       <= KP_RESET;
      ki_q       <= KI_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_LEFT:  target_l_q <= cfg_data_i[TARGET_W-1:0];
        CFG_TARGET_RIGHT: target_r_q <= cfg_data_i[TARGET_W-1:0];
        CFG_KP_GAIN:      kp_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_KI_GAIN:      ki_q       <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // each stage advances when the one after it is free or draining
  assign en3   = !v3_q || m_axis_tready;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign s_axis_tready = en1;
  assign s_acc = s_axis_tvalid && en1;

  assign ctl.load2 = en2 && v1_q;
  assign ctl.load3 = en3 && v2_q;
  assign ctl.upd2  = upd2_q;

  dwsc_front #(
    .PERIOD_TICKS(PERIOD_TICKS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (s_acc),
    .left_pulse_i   (s_axis_tdata[0]),
    .right_pulse_i  (s_axis_tdata[1]),
    .ms_tick_i      (s_axis_tdata[2]),
    .clear_i        (s_axis_tdata[3]),
    .target_left_i  (target_l_q),
    .target_right_i (target_r_q),
    .out_o          (front_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_acc;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_q <= front_out;
    end
    if (ctl.load2) begin
      tl2_q  <= s1_q.total_left;
      tr2_q  <= s1_q.total_right;
      upd2_q <= s1_q.updated;
    end
    if (ctl.load3) begin
      tl3_q  <= tl2_q;
      tr3_q  <= tr2_q;
      upd3_q <= upd2_q;
    end
  end

  dwsc_lane #(
    .CORRECTION_LIMIT(CORRECTION_LIMIT)
  ) u_lane_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .op_i      (s1_q.left),
    .kp_gain_i (kp_q),
    .ki_gain_i (ki_q),
    .duty_o    (duty_left)
  );

  dwsc_lane #(
    .CORRECTION_LIMIT(CORRECTION_LIMIT)
  ) u_lane_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .op_i      (s1_q.right),
    .kp_gain_i (kp_q),
    .ki_gain_i (ki_q),
    .duty_o    (duty_right)
  );

  // merge both lanes with the carried totals into one result item
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {7'b0, upd3_q, tr3_q, tl3_q, duty_right, duty_left};

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v3_q |-> s_axis_tready)
    else $error("input blocked while output stage is empty");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && en3) |=> m_axis_tvalid)
    else $error("result lost between last two stages");

endmodule
`default_nettype wire

### dv/dual_wheel_sync_speed_controller_tb.sv
`timescale 1ns / 100ps
module dual_wheel_sync_speed_controller_tb;
  import dwsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AT     = 300;   // item count that triggers the long stall
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_WAIT  = 4;     // pipe is 3 stages deep

  // one encoder/tick sample, left_pulse in bit 0
  typedef struct packed {
    logic clear_totals;
    logic ms_tick;
    logic right_pulse;
    logic left_pulse;
  } pulse_item_t;

  // one result, packed as on m_axis_tdata[64:0]
  typedef struct packed {
    logic        updated;
    logic [15:0] total_right;
    logic [15:0] total_left;
    logic [15:0] duty_right;
    logic [15:0] duty_left;
  } result_t;

  typedef struct {
    pulse_item_t item;
    bit          typed;
    result_t     want;
  } dir_row_t;

  typedef struct {
    logic [6:0]  tl;
    logic [6:0]  tr;
    logic [15:0] kp;
    logic [15:0] ki;
    int unsigned tick_div;
    int unsigned noise_pct;
    int unsigned pct_lo;
    int unsigned n_items;
  } phase_t;

  localparam result_t ZERO_RES = '0;

  // columns of item: clear, tick, right, left
  dir_row_t dir_rows [16] = '{
    '{4'b0000, 1'b1, ZERO_RES},
    '{4'b0001, 1'b1, ZERO_RES},
    '{4'b0011, 1'b1, ZERO_RES},
    '{4'b1000, 1'b1, ZERO_RES},
    '{4'b0101, 1'b0, ZERO_RES},
    '{4'b0111, 1'b0, ZERO_RES},
    '{4'b0100, 1'b0, ZERO_RES},
    '{4'b0001, 1'b0, ZERO_RES},
    '{4'b0110, 1'b0, ZERO_RES},
    '{4'b0101, 1'b0, ZERO_RES},
    '{4'b0111, 1'b0, ZERO_RES},
    '{4'b0100, 1'b0, ZERO_RES},
    '{4'b0101, 1'b0, ZERO_RES},
    '{4'b0110, 1'b0, ZERO_RES},
    // tenth tick with a pulse and a clear: update, report, then zero the totals
    '{4'b1101, 1'b0, ZERO_RES},
    '{4'b0000, 1'b1, ZERO_RES}
  };

  phase_t phase_plan [7] = '{
    '{7'd127, 7'd127, 16'd5120,  16'd102,   2, 10,  0, 220},
    '{7'd0,   7'd0,   16'd65535, 16'd65535, 2, 10,  0, 220},
    '{7'd64,  7'd20,  16'd0,     16'd0,     3, 20,  0, 220},
    '{7'd127, 7'd0,   16'd65535, 16'd0,    40,  0, 70, 600},
    '{7'd50,  7'd50,  16'd5120,  16'd65535, 2, 10,  0, 220},
    '{7'd0,   7'd0,   16'd0,     16'd0,     4, 25,  0, 220},
    '{7'd0,   7'd127, 16'd0,     16'd65535, 2, 10,  0, 220}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [71:0]           m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_TARGET_LEFT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // predictor state and register copies
  logic [3:0]  tick_phase;
  logic [6:0]  lpulses, rpulses;
  logic [15:0] ltot, rtot, lduty, rduty;
  logic [6:0]  tgt_l, tgt_r;
  logic [15:0] kp_q10, ki_q10;

  result_t     duty_expect_q[$];
  int unsigned items_sent;
  int unsigned fails;
  int unsigned updates_seen;
  int unsigned full_duty_seen;
  int unsigned results_seen;
  int unsigned cycle_cnt;
  int unsigned rx_gap;
  int unsigned hold_left;
  bit          hold_done;
  bit          idle_on;

  dual_wheel_sync_speed_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic void wheel_reset();
    tick_phase = '0;
    lpulses    = '0;
    rpulses    = '0;
    ltot       = '0;
    rtot       = '0;
    lduty      = '0;
    rduty      = '0;
    tgt_l      = '0;
    tgt_r      = '0;
    kp_q10     = KP_RESET;
    ki_q10     = KI_RESET;
  endfunction

  function automatic logic [15:0] duty_after(input logic [15:0] duty, input logic [6:0] target,
                                             input logic [6:0] count, input longint sync);
    longint corr, lim, sum;
    lim  = longint'(CORR_LIMIT_DEF);
    corr = longint'(kp_q10) * (longint'(target) - longint'(count)) + longint'(ki_q10) * sync;
    if (corr > lim) begin
      corr = lim;
    end else if (corr < -lim) begin
      corr = -lim;
    end
    sum = longint'(duty) + corr;
    if (sum < 0) begin
      sum = 0;
    end else if (sum > 65535) begin
      sum = 65535;
    end
    return sum[15:0];
  endfunction

  function automatic result_t wheel_step(input pulse_item_t it);
    result_t            r;
    logic [3:0]         nxt;
    logic signed [15:0] skew;
    longint             diff;
    r = '0;
    if (it.left_pulse && lpulses != 7'd127) lpulses = lpulses + 7'd1;
    if (it.right_pulse && rpulses != 7'd127) rpulses = rpulses + 7'd1;
    if (it.ms_tick) begin
      nxt = tick_phase + 4'd1;
      if (nxt >= PERIOD_TICKS_DEF) begin
        tick_phase = '0;
        ltot       = ltot + 16'(lpulses);
        rtot       = rtot + 16'(rpulses);
        skew       = signed'(ltot - rtot);
        diff       = skew;
        lduty      = duty_after(lduty, tgt_l, lpulses, -diff);
        rduty      = duty_after(rduty, tgt_r, rpulses, diff);
        lpulses    = '0;
        rpulses    = '0;
        r.updated  = 1'b1;
      end else begin
        tick_phase = nxt;
      end
    end
    r.duty_left   = lduty;
    r.duty_right  = rduty;
    r.total_left  = ltot;
    r.total_right = rtot;
    if (it.clear_totals) begin
      ltot = '0;
      rtot = '0;
    end
    return r;
  endfunction

  // enter and leave at a falling edge
  task automatic send_item(input pulse_item_t it, input bit typed, input result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, it};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = wheel_step(it);
    duty_expect_q.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TARGET_LEFT:  tgt_l  = val[6:0];
      CFG_TARGET_RIGHT: tgt_r  = val[6:0];
      CFG_KP_GAIN:      kp_q10 = val;
      CFG_KI_GAIN:      ki_q10 = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (duty_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // receiver: random stalls after each item plus one long hold-off
  always @(negedge clk_i) begin
    if (!hold_done && items_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_mon
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rx_gap = idle_on ? $urandom_range(0, 3) : 0;
      results_seen++;
      if (m_axis_tdata[64]) updates_seen++;
      if (m_axis_tdata[15:0] == 16'hFFFF || m_axis_tdata[31:16] == 16'hFFFF) full_duty_seen++;
      if (duty_expect_q.size() == 0) begin
        $error("result item with no expectation pending: %h", m_axis_tdata);
        fails++;
      end else begin
        want = duty_expect_q.pop_front();
        check_field("duty_left", want.duty_left, m_axis_tdata[15:0]);
        check_field("duty_right", want.duty_right, m_axis_tdata[31:16]);
        check_field("total_left", want.total_left, m_axis_tdata[47:32]);
        check_field("total_right", want.total_right, m_axis_tdata[63:48]);
        check_field("updated", want.updated, m_axis_tdata[64]);
        check_field("pad", 0, m_axis_tdata[71:65]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_cnt, duty_expect_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    pulse_item_t it;
    phase_t      ph;
    int unsigned lpct, rpct;
    wheel_reset();
    repeat (4) @(negedge clk_i);
    rst_ni  <= 1'b1;
    idle_on  = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    phase_plan[5].tl = 7'($urandom);
    phase_plan[5].tr = 7'($urandom);
    phase_plan[5].kp = 16'($urandom);
    phase_plan[5].ki = 16'($urandom_range(0, 4095));

    foreach (phase_plan[p]) begin
      ph = phase_plan[p];
      drain();
      // junk in the unused upper bits of the target writes
      cfg_write(CFG_TARGET_LEFT, {9'($urandom), ph.tl});
      cfg_write(CFG_TARGET_RIGHT, {9'($urandom), ph.tr});
      cfg_write(CFG_KP_GAIN, ph.kp);
      cfg_write(CFG_KI_GAIN, ph.ki);
      cfg_valid_i <= 1'b0;
      for (int unsigned n = 0; n < ph.n_items; n++) begin
        if (n % 40 == 0) begin
          lpct    = $urandom_range(ph.pct_lo, 100);
          rpct    = $urandom_range(ph.pct_lo, 100);
          idle_on = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 99) < ph.noise_pct) begin
          it              = pulse_item_t'($urandom_range(0, 15));
          it.clear_totals = it.clear_totals && ($urandom_range(0, 7) == 0);
        end else begin
          it.left_pulse   = ($urandom_range(0, 99) < lpct);
          it.right_pulse  = ($urandom_range(0, 99) < rpct);
          it.ms_tick      = ($urandom_range(0, ph.tick_div - 1) == 0);
          it.clear_totals = ($urandom_range(0, 79) == 0);
        end
        send_item(it, 1'b0, ZERO_RES);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d items and %0d results over %0d register settings",
             items_sent, results_seen, $size(phase_plan) + 1);
    $display("Control updates: %0d, results with a duty at full scale: %0d",
             updates_seen, full_duty_seen);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fails);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
